// File: sv/trsq_pkg.sv
// Package for the tagged radius sorted query block.
// Holds sizes, field widths, mode and result codes. No dependencies.
`default_nettype none
package trsq_pkg;
	localparam int MaxTargets = 64;
	localparam int TagCount   = 8;
	localparam int IdxW       = 6;
	localparam int CntW       = 7;
	localparam int DistW      = 34;

	localparam logic [1:0] ModeLoad  = 2'd0;
	localparam logic [1:0] ModeClear = 2'd1;
	localparam logic [1:0] ModeQuery = 2'd2;
	localparam logic [1:0] ModeRsvd  = 2'd3;

	localparam logic [1:0] KindDone    = 2'd0;
	localparam logic [1:0] KindFull    = 2'd1;
	localparam logic [1:0] KindMatch   = 2'd2;
	localparam logic [1:0] KindNoMatch = 2'd3;

	localparam logic [7:0] TagMask = 8'((9'd1 << TagCount) - 9'd1);

	typedef struct packed {
		logic [DistW-1:0] dsq;
		logic [IdxW-1:0]  idx;
	} entry_t;

	typedef struct packed {
		logic   clr;
		logic   ins;
		entry_t ent;
		logic   shift;
	} cell_ctl_t;
endpackage
`default_nettype wire

// File: sv/trsq_cell.sv
// One sorting cell of the insertion chain for the query block.
// Uses trsq_pkg; neighbor data comes from the previous cell, or the next on a shift.
`default_nettype none
module trsq_cell import trsq_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cell_ctl_t ctl,
	input  wire logic      left_valid,
	input  wire entry_t    left_ent,
	input  wire logic      left_gt,
	output logic           valid_q,
	output entry_t         ent_q,
	output logic           gt
);
	assign gt = valid_q && (ent_q.dsq > ctl.ent.dsq);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clr) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= left_valid;
			ent_q   <= left_ent;
		end else if (ctl.ins) begin
			if (left_gt) begin
				valid_q <= left_valid;
				ent_q   <= left_ent;
			end else if (gt || !valid_q) begin
				if (!left_valid) begin
					valid_q <= valid_q;
				end
				if (left_valid && (gt || !valid_q)) begin
					valid_q <= 1'b1;
					ent_q   <= ctl.ent;
				end
			end
		end
	end
endmodule
`default_nettype wire

// File: sv/trsq_store.sv
// Target store of the query block: positions and tag sets, one read port.
// Uses trsq_pkg.
`default_nettype none
module trsq_store import trsq_pkg::*; (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [IdxW-1:0] waddr,
	input  wire logic [55:0]     wdata,
	input  wire logic [IdxW-1:0] raddr,
	output logic [55:0]          rdata_q
);
	logic [55:0] mem [MaxTargets];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: sv/tagged_radius_sorted_query.sv
// Top level of the tagged radius sorted query block.
// Uses trsq_pkg, trsq_store and a chain of trsq_cell sorting cells.
//
// channel | dir | handshake      | payload
// in      | in  | in_valid/stall | mode pos_x pos_y pos_z radius tag_bits query_tag
// out     | out | out_valid/stall| kind target_index dist_sq last
//
// Load and clear each answer with a single registered result. A query scans
// one target a cycle through the store read port, distance stages and the cell
// chain, then gives one result per cycle while the output is not stalled.
// Reset empties the store count and the chain. Output stall holds the result
// register; a new item is taken only after the previous one is fully sent.
`default_nettype none
module tagged_radius_sorted_query import trsq_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         mode,
	input  wire logic signed [15:0] pos_x,
	input  wire logic signed [15:0] pos_y,
	input  wire logic signed [15:0] pos_z,
	input  wire logic [15:0]        radius,
	input  wire logic [7:0]         tag_bits,
	input  wire logic [2:0]         query_tag,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              kind,
	output logic [IdxW-1:0]         target_index,
	output logic [DistW-1:0]        dist_sq,
	output logic                    last
);
	typedef enum logic [2:0] {StIdle, StScan, StDrain, StEmit, StOne} st_t;
	st_t st_q;

	logic [CntW-1:0] count_q, scan_q;
	logic signed [15:0] cx_q, cy_q, cz_q;
	logic [31:0] rsq_q;
	logic [2:0]  tag_q;
	logic [55:0] rdata_q;
	logic [7:0]  rtag;
	logic        v_s1, v_s2, v_s3;
	logic [IdxW-1:0] i_s1, i_s2, i_s3;
	logic [31:0] sx_s2, sy_s2, sz_s2;
	logic        hit_s2;
	logic [DistW-1:0] d_s3;
	logic        hit_s3;
	logic [1:0]  okind_q;
	logic        ovalid_q;
	logic        olast_q;
	logic [IdxW-1:0] oidx_q;
	logic [DistW-1:0] odist_q;
	logic        any_q;

	wire in_xfer  = in_valid && !in_stall;
	wire out_xfer = ovalid_q && !out_stall;
	assign in_stall = (st_q != StIdle) || ovalid_q;

	wire store_we = in_xfer && mode == ModeLoad && count_q < CntW'(MaxTargets);

	trsq_store u_store (
		.clk(clk), .we(store_we), .waddr(count_q[IdxW-1:0]),
		.wdata({pos_x, pos_y, pos_z, tag_bits & TagMask}),
		.raddr(scan_q[IdxW-1:0]), .rdata_q(rdata_q)
	);

	assign rtag = rdata_q[7:0];

	function automatic logic [31:0] sqd(input logic [15:0] a, input logic signed [15:0] b);
		logic signed [16:0] d;
		logic [16:0] u;
		logic [33:0] p;
		begin
			d = 17'(signed'(a)) - 17'(b);
			u = d[16] ? 17'(-d) : 17'(d);
			p = 34'(u) * 34'(u);
			sqd = p[31:0];
		end
	endfunction

	always_ff @(posedge clk) begin
		sx_s2  <= sqd(rdata_q[55:40], cx_q);
		sy_s2  <= sqd(rdata_q[39:24], cy_q);
		sz_s2  <= sqd(rdata_q[23:8], cz_q);
		hit_s2 <= rtag[tag_q];
		i_s2   <= i_s1;
		d_s3   <= DistW'(sx_s2) + DistW'(sy_s2) + DistW'(sz_s2);
		hit_s3 <= hit_s2;
		i_s3   <= i_s2;
	end

	wire ins = v_s3 && hit_s3 && d_s3 <= DistW'(rsq_q);
	cell_ctl_t ctl;
	assign ctl.clr   = in_xfer && mode == ModeQuery;
	assign ctl.ins   = ins && st_q != StEmit;
	assign ctl.ent   = '{dsq: d_s3, idx: i_s3};
	assign ctl.shift = st_q == StEmit && (!ovalid_q || out_xfer);

	logic   cv   [MaxTargets+1];
	entry_t ce   [MaxTargets+1];
	logic   cg   [MaxTargets+1];
	assign cv[0] = 1'b1;
	assign ce[0] = ctl.ent;
	assign cg[0] = 1'b0;
	logic   rv   [MaxTargets];
	entry_t re   [MaxTargets];
	logic   rg   [MaxTargets];

	for (genvar k = 0; k < MaxTargets; k++) begin : g_cell
		logic   lv;
		entry_t le;
		assign lv = ctl.shift ? (k == MaxTargets-1 ? 1'b0 : rv[(k+1)%MaxTargets]) : cv[k];
		assign le = ctl.shift ? re[(k+1)%MaxTargets] : ce[k];
		trsq_cell u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl), .left_valid(lv), .left_ent(le),
			.left_gt(ctl.shift ? 1'b0 : cg[k]), .valid_q(rv[k]), .ent_q(re[k]),
			.gt(rg[k])
		);
		assign cv[k+1] = rv[k];
		assign ce[k+1] = re[k];
		assign cg[k+1] = rg[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= StIdle; count_q <= '0; scan_q <= '0; ovalid_q <= 1'b0;
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; any_q <= 1'b0;
		end else begin
			v_s2 <= v_s1; v_s3 <= v_s2;
			v_s1 <= 1'b0;
			if (out_xfer) ovalid_q <= 1'b0;
			if (ins) any_q <= 1'b1;
			case (st_q)
				StIdle: begin
					if (in_xfer) begin
						cx_q <= pos_x; cy_q <= pos_y; cz_q <= pos_z;
						rsq_q <= 32'(radius) * 32'(radius); tag_q <= query_tag;
						scan_q <= '0; any_q <= 1'b0;
						oidx_q <= '0; odist_q <= '0; olast_q <= 1'b1;
						case (mode)
							ModeLoad: begin
								ovalid_q <= 1'b1;
								if (store_we) begin
									count_q <= count_q + 1'b1; okind_q <= KindDone;
								end else begin
									okind_q <= KindFull;
								end
							end
							ModeClear: begin
								count_q <= '0; ovalid_q <= 1'b1; okind_q <= KindDone;
							end
							ModeQuery: begin
								if (radius == '0 || 32'(query_tag) >= TagCount) begin
									ovalid_q <= 1'b1; okind_q <= KindNoMatch;
								end else begin
									st_q <= StScan;
								end
							end
							default: ;
						endcase
					end
				end
				StScan: begin
					if (scan_q < count_q) begin
						v_s1 <= 1'b1; i_s1 <= scan_q[IdxW-1:0];
						scan_q <= scan_q + 1'b1;
					end else begin
						st_q <= StDrain;
					end
				end
				StDrain: begin
					if (!v_s1 && !v_s2 && !v_s3) st_q <= any_q ? StEmit : StOne;
				end
				StOne: begin
					ovalid_q <= 1'b1; okind_q <= KindNoMatch; oidx_q <= '0;
					odist_q <= '0; olast_q <= 1'b1; st_q <= StIdle;
				end
				StEmit: begin
					if (ctl.shift) begin
						ovalid_q <= 1'b1; okind_q <= KindMatch;
						oidx_q <= re[0].idx; odist_q <= re[0].dsq;
						olast_q <= !rv[1 % MaxTargets] || MaxTargets == 1;
						if (!rv[1 % MaxTargets]) st_q <= StIdle;
					end
				end
				default: st_q <= StIdle;
			endcase
		end
	end

	assign out_valid = ovalid_q;
	assign kind = okind_q;
	assign target_index = oidx_q;
	assign dist_sq = odist_q;
	assign last = olast_q;

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != StIdle) |-> in_stall) else $error("input taken while busy");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(MaxTargets)) else $error("store count overflow");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && out_stall) |=> ovalid_q && $stable(odist_q))
		else $error("result dropped under stall");
endmodule
`default_nettype wire

// File: tb/tb.sv
// Testbench for tagged_radius_sorted_query: random and directed load, clear, query
// and reserved-mode transfers, with a built-in predictor of the target store and
// sorted match lists. Depends on trsq_pkg and the tagged_radius_sorted_query RTL.
`default_nettype none
module tb;
	import trsq_pkg::*;

	typedef struct {
		logic [1:0]         mode;
		logic signed [15:0] x, y, z;
		logic [15:0]        radius;
		logic [7:0]         tags;
		logic [2:0]         qtag;
	} req_t;

	typedef struct {
		logic [1:0]       kind;
		logic [IdxW-1:0]  idx;
		logic [DistW-1:0] dsq;
		logic             last;
	} res_t;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0;
	logic [1:0] mode = 0;
	logic signed [15:0] pos_x = 0, pos_y = 0, pos_z = 0;
	logic [15:0] radius = 0;
	logic [7:0] tag_bits = 0;
	logic [2:0] query_tag = 0;
	logic [1:0] kind;
	logic [IdxW-1:0] target_index;
	logic [DistW-1:0] dist_sq;
	logic last;

	req_t pending[$];
	res_t expected[$];
	int errors = 0;
	bit stim_done = 0;
	int hold_rx = 0;
	bit pause_tx = 0;

	logic signed [15:0] st_x[MaxTargets], st_y[MaxTargets], st_z[MaxTargets];
	logic [7:0] st_tags[MaxTargets];
	int st_count = 0;

	tagged_radius_sorted_query i_dut (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic void add_exp(res_t e);
		expected.insert(expected.size(), e);
	endfunction

	function automatic void add_req(req_t r);
		pending.insert(pending.size(), r);
	endfunction

	function automatic logic [DistW-1:0] sq(logic signed [15:0] a, logic signed [15:0] b);
		longint d;
		d = longint'(a) - longint'(b);
		return DistW'(d * d);
	endfunction

	function automatic void predict_results(req_t r);
		logic [DistW-1:0] d, rsq;
		logic [DistW-1:0] md[$];
		int mi[$];
		int j;
		res_t e;
		case (r.mode)
			ModeLoad: begin
				e = '{KindDone, 0, 0, 1};
				if (st_count >= MaxTargets) e.kind = KindFull;
				else begin
					st_x[st_count] = r.x; st_y[st_count] = r.y; st_z[st_count] = r.z;
					st_tags[st_count] = r.tags & TagMask;
					st_count++;
				end
				add_exp(e);
			end
			ModeClear: begin
				st_count = 0;
				add_exp('{KindDone, 0, 0, 1});
			end
			ModeQuery: begin
				rsq = DistW'(r.radius) * DistW'(r.radius);
				if (r.radius != 0 && r.qtag < TagCount) begin
					for (int i = 0; i < st_count; i++) begin
						if (!st_tags[i][r.qtag]) continue;
						d = sq(st_x[i], r.x) + sq(st_y[i], r.y) + sq(st_z[i], r.z);
						if (d > rsq) continue;
						j = md.size();
						while (j > 0 && md[j-1] > d) j--;
						md.insert(j, d);
						mi.insert(j, i);
					end
				end
				if (md.size() == 0) add_exp('{KindNoMatch, 0, 0, 1});
				for (int k = 0; k < md.size(); k++)
					add_exp('{KindMatch, IdxW'(mi[k]), md[k], k == md.size() - 1});
			end
			default: ;
		endcase
	endfunction

	function automatic logic signed [15:0] rand_coord(bit near);
		int v;
		if (near) v = $urandom_range(0, 1600) - 800;
		else case ($urandom_range(0, 3))
			0: v = -32768;
			1: v = 32767;
			default: v = $urandom_range(0, 65535) - 32768;
		endcase
		return 16'(v);
	endfunction

	function automatic req_t rand_req(int sel);
		req_t r;
		bit near;
		near = $urandom_range(0, 4) != 0;
		r.x = rand_coord(near);
		r.y = rand_coord(near);
		r.z = rand_coord(near);
		r.tags = 8'($urandom);
		r.qtag = 3'($urandom);
		r.radius = $urandom_range(0, 9) == 0 ? 16'($urandom)
			: 16'($urandom_range(0, 1500));
		if (sel < 50) r.mode = ModeLoad;
		else if (sel < 53) r.mode = ModeClear;
		else if (sel < 95) r.mode = ModeQuery;
		else r.mode = ModeRsvd;
		return r;
	endfunction

	function automatic req_t mk(logic [1:0] m, int x, int y, int z, int rad, int tg, int qt);
		req_t r;
		r = '{m, 16'(x), 16'(y), 16'(z), 16'(rad), 8'(tg), 3'(qt)};
		return r;
	endfunction

	initial begin
		int n;
		add_req(mk(ModeQuery, 0, 0, 0, 100, 8'hFF, 0));
		add_req(mk(ModeLoad, 0, 0, 0, 0, 8'hFF, 0));
		add_req(mk(ModeLoad, 16, 0, 0, 0, 8'h01, 0));
		add_req(mk(ModeLoad, -16, 0, 0, 0, 8'h81, 0));
		add_req(mk(ModeLoad, 0, 16, 0, 0, 8'h80, 0));
		add_req(mk(ModeLoad, -32768, -32768, -32768, 0, 8'hFF, 0));
		add_req(mk(ModeLoad, 32767, 32767, 32767, 0, 8'hAA, 0));
		add_req(mk(ModeRsvd, 1, 2, 3, 4, 5, 6));
		add_req(mk(ModeQuery, 0, 0, 0, 16, 0, 0));
		add_req(mk(ModeQuery, 0, 0, 0, 0, 0, 0));
		add_req(mk(ModeQuery, 0, 0, 0, 16, 0, 7));
		add_req(mk(ModeQuery, 0, 0, 0, 15, 0, 3));
		add_req(mk(ModeQuery, 32767, 32767, 32767, 65535, 0, 1));
		add_req(mk(ModeQuery, -32768, -32768, -32768, 65535, 0, 0));
		add_req(mk(ModeQuery, 32767, -32768, 32767, 65535, 0, 7));
		add_req(mk(ModeClear, 0, 0, 0, 0, 0, 0));
		add_req(mk(ModeQuery, 0, 0, 0, 65535, 0, 0));
		for (int i = 0; i < 66; i++)
			add_req(mk(ModeLoad, i % 3 * 16, 0, 0, 0, 8'hFF, 0));
		add_req(mk(ModeQuery, 0, 0, 0, 65535, 0, 5));
		add_req(mk(ModeClear, 0, 0, 0, 0, 0, 0));
		wait (arst_n);
		// long receiver hold while the sender keeps offering
		hold_rx = 400;
		wait (pending.size() == 0);
		pause_tx = 1;
		wait (expected.size() == 0);
		repeat (4) @(posedge clk);
		pause_tx = 0;
		n = 0;
		while (n < 185) begin
			req_t r;
			r = rand_req($urandom_range(0, 99));
			add_req(r);
			n++;
			if (pending.size() > 8) wait (pending.size() < 4);
		end
		wait (pending.size() == 0);
		stim_done = 1;
	end

	// sender
	int gap_tx = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_results(pending.pop_front());
				gap_tx = $urandom_range(0, 9) == 0 ? $urandom_range(5, 40)
					: ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
			end
			if (!(in_valid && in_stall)) begin
				if (gap_tx > 0) begin
					gap_tx <= gap_tx - 1;
					in_valid <= 0;
				end else if (pause_tx || pending.size() == 0) begin
					in_valid <= 0;
				end else begin
					req_t r;
					r = pending[0];
					in_valid <= 1;
					mode <= r.mode;
					pos_x <= r.x;
					pos_y <= r.y;
					pos_z <= r.z;
					radius <= r.radius;
					tag_bits <= r.tags;
					query_tag <= r.qtag;
				end
			end
		end
	end

	// receiver
	int gap_rx = 0;
	always @(posedge clk) begin
		res_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected.size() == 0) begin
					$error("unexpected result kind=%0d", kind);
					errors++;
				end else begin
					e = expected.pop_front();
					if (kind !== e.kind) begin
						$error("kind exp %0d got %0d", e.kind, kind); errors++;
					end
					if (target_index !== e.idx) begin
						$error("target_index exp %0d got %0d", e.idx, target_index); errors++;
					end
					if (dist_sq !== e.dsq) begin
						$error("dist_sq exp %0d got %0d", e.dsq, dist_sq); errors++;
					end
					if (last !== e.last) begin
						$error("last exp %0d got %0d", e.last, last); errors++;
					end
				end
			end
			if (hold_rx > 0) begin
				hold_rx <= hold_rx - 1;
				out_stall <= 1;
			end else if (gap_rx > 0) begin
				gap_rx <= gap_rx - 1;
				out_stall <= 1;
			end else begin
				gap_rx <= $urandom_range(0, 14) == 0 ? $urandom_range(5, 40)
					: ($urandom_range(0, 2) == 0 ? $urandom_range(0, 3) : 0);
				out_stall <= 0;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		wait (stim_done);
		wait (expected.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0 && expected.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#100000000;
		$display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire
